// ===== hw/rtl/rxdlrr_pkg.sv =====
// shared types and constants of the rtcp xr dlrr round-trip parser
package rxdlrr_pkg;

    localparam int unsigned RTT_SCALE  = 1000;  // milliseconds per second
    localparam int unsigned FRAC_BITS  = 16;    // fraction bits of compact ntp
    localparam int unsigned DLRR_GROUP = 12;    // bytes per dlrr sub-block

    localparam logic [7:0] PT_XR     = 8'd207;
    localparam logic [7:0] BT_DLRR   = 8'd5;

    localparam logic KIND_RTT    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_XR    = 2'd1;
    localparam logic [1:0] ST_LEN_OVER  = 2'd2;
    localparam logic [1:0] ST_BLK_OVER  = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_BLK_HDR = 3'd1,
        PH_DLRR    = 3'd2,
        PH_SKIP    = 3'd3,
        PH_IDLE    = 3'd4
    } phase_t;

    // what one accepted item leaves for the result side
    typedef struct packed {
        logic        rtt;
        logic        stat;
        logic [31:0] src;
        logic [31:0] diff;
        logic [1:0]  status;
    } evt_t;

endpackage

// ===== hw/rtl/rtcp_xr_dlrr_rtt_parser_core.sv =====
// top level: rtcp xr dlrr round-trip parser with result buffering
//
// Input channel (in_valid/in_ready) carries one packet byte per item with the
// packet length, the current compact ntp time and a last-byte flag. Output
// channel (out_valid/out_ready) carries results: a round-trip result for each
// complete dlrr sub-block while recv_only is set, and a status result on the
// last byte of a packet. One item gives at most two results, the round trip
// first. cfg_we/cfg_wdata write recv_only; write it only while the block is idle,
// which the block itself does not enforce. Results pass through the parse stage
// register, then the result register after the x1000 scaling, before they show.
// Throughput: one item per cycle while the receiver takes results; an item
// that gives two results holds the result register for two handshakes, and
// the input stalls behind it until its status result goes out.
// Reset clears the parse state to the packet header, empties both stages and
// sets recv_only. When out_ready is low, results wait in the result register,
// one further item is held in the parse stage, and then in_ready drops.
module rtcp_xr_dlrr_rtt_parser_core
    import rxdlrr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         packet_byte,
    input  logic [15:0]        packet_length,
    input  logic [31:0]        now_compact_ntp,
    input  logic               last_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               result_kind,
    output logic [31:0]        source_id,
    output logic signed [31:0] rtt_ms,
    output logic [1:0]         status,
    output logic               last_result
);

    logic               recv_only_reg;
    logic               in_fire;
    evt_t               evt;
    logic               s1_valid_reg;
    evt_t               s1_evt_reg;
    logic               s1_adv;
    logic               rtt_pend_reg, rtt_pend_next;
    logic               stat_pend_reg, stat_pend_next;
    logic [31:0]        src_reg;
    logic signed [31:0] rtt_reg;
    logic [1:0]         status_reg;
    logic               out_fire;
    logic               s2_free;
    logic               load;
    logic signed [47:0] prod;

    assign in_fire = in_valid && in_ready;

    rxdlrr_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (in_fire),
        .recv_only       (recv_only_reg),
        .packet_byte     (packet_byte),
        .packet_length   (packet_length),
        .now_compact_ntp (now_compact_ntp),
        .last_byte       (last_byte),
        .evt             (evt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            recv_only_reg <= 1'b1;
        else if (cfg_we)
            recv_only_reg <= cfg_wdata;
    end

    // result register frees when empty or when its final result goes out
    assign out_valid = rtt_pend_reg || stat_pend_reg;
    assign out_fire  = out_valid && out_ready;
    assign s2_free   = !out_valid || (out_fire && !(rtt_pend_reg && stat_pend_reg));
    assign load      = s1_valid_reg && s2_free;
    assign s1_adv    = !s1_valid_reg || load;
    assign in_ready  = s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_adv)
            s1_valid_reg <= in_fire && (evt.rtt || evt.stat);
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            s1_evt_reg <= evt;
    end

    // signed difference times 1000, floored by the 16 fraction bits
    assign prod = 48'(signed'(s1_evt_reg.diff)) * 48'(RTT_SCALE);

    always_comb
    begin
        rtt_pend_next  = rtt_pend_reg;
        stat_pend_next = stat_pend_reg;
        if (out_fire)
        begin
            if (rtt_pend_reg)
                rtt_pend_next = 1'b0;
            else
                stat_pend_next = 1'b0;
        end
        if (load)
        begin
            rtt_pend_next  = s1_evt_reg.rtt;
            stat_pend_next = s1_evt_reg.stat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rtt_pend_reg  <= 1'b0;
            stat_pend_reg <= 1'b0;
        end
        else
        begin
            rtt_pend_reg  <= rtt_pend_next;
            stat_pend_reg <= stat_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            src_reg    <= s1_evt_reg.src;
            rtt_reg    <= prod[FRAC_BITS +: 32];
            status_reg <= s1_evt_reg.status;
        end
    end

    assign result_kind = rtt_pend_reg ? KIND_RTT : KIND_STATUS;
    assign source_id   = rtt_pend_reg ? src_reg : 32'd0;
    assign rtt_ms      = rtt_pend_reg ? rtt_reg : 32'sd0;
    assign status      = rtt_pend_reg ? ST_OK : status_reg;
    assign last_result = !(rtt_pend_reg && stat_pend_reg);

    // a status result always closes the results of its item
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == KIND_STATUS) |-> last_result)
        else $error("status result not marked last");

    // a non-final result is a round trip followed at once by the status
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !last_result) |=> (out_valid && result_kind == KIND_STATUS))
        else $error("status result lost after round-trip result");

    // round-trip results only appear while enabled
    a_rtt_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == KIND_RTT) |-> recv_only_reg)
        else $error("round-trip result while not receive-only");

    // a waiting parse stage blocks the input unless the result side takes it
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_free) |-> !in_ready)
        else $error("input accepted over a held item");

endmodule

// ===== hw/rtl/rxdlrr_parser.sv =====
// byte-wise packet walker: header and block checks, dlrr field capture
module rxdlrr_parser
    import rxdlrr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        recv_only,
    input  logic [7:0]  packet_byte,
    input  logic [15:0] packet_length,
    input  logic [31:0] now_compact_ntp,
    input  logic        last_byte,
    output evt_t        evt
);

    phase_t       phase_reg, phase_next;
    logic [15:0]  pos_reg, pos_next;
    logic [15:0]  decl_len_reg, decl_len_next;
    logic [15:0]  blk_len_reg, blk_len_next;
    logic [7:0]   blk_type_reg, blk_type_next;
    logic [15:0]  blk_cnt_reg, blk_cnt_next;
    logic [3:0]   grp_reg, grp_next;
    logic [95:0]  shift_reg, shift_next;
    logic [1:0]   err_reg, err_next;

    logic [18:0]  hdr_total;
    logic [18:0]  blk_total;
    logic [19:0]  blk_end;
    logic [16:0]  q_next_byte;
    logic [15:0]  cnt_inc;
    logic [95:0]  shift_in;
    logic [1:0]   st;

    // phase after a header or block that ends just before byte q
    function automatic phase_t after_block(input logic [16:0] q, input logic [15:0] decl);
        logic [17:0] qa;
        begin
            qa = {1'b0, q} + 18'd4;
            after_block = (qa < {2'b0, decl}) ? PH_BLK_HDR : PH_IDLE;
        end
    endfunction

    assign hdr_total   = ({3'b0, decl_len_reg | {8'b0, packet_byte}} + 19'd1) << 2;
    assign blk_total   = ({3'b0, blk_len_reg | {8'b0, packet_byte}} + 19'd1) << 2;
    assign blk_end     = {4'b0, pos_reg} - 20'd3 + {1'b0, blk_total};
    assign q_next_byte = {1'b0, pos_reg} + 17'd1;
    assign cnt_inc     = blk_cnt_reg + 16'd1;
    assign shift_in    = {shift_reg[87:0], packet_byte};

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        decl_len_next = decl_len_reg;
        blk_len_next  = blk_len_reg;
        blk_type_next = blk_type_reg;
        blk_cnt_next  = blk_cnt_reg;
        grp_next      = grp_reg;
        shift_next    = shift_reg;
        err_next      = err_reg;
        evt           = '0;
        st            = ST_OK;

        case (phase_reg)
            PH_HEADER:
            begin
                if (pos_reg == 16'd1)
                begin
                    if (packet_byte != PT_XR)
                    begin
                        err_next   = ST_NOT_XR;
                        phase_next = PH_IDLE;
                    end
                end
                else if (pos_reg == 16'd2)
                begin
                    decl_len_next = {packet_byte, 8'b0};
                end
                else if (pos_reg == 16'd3)
                begin
                    if (hdr_total > {3'b0, packet_length})
                    begin
                        err_next   = ST_LEN_OVER;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        decl_len_next = hdr_total[15:0];
                    end
                end
                else if (pos_reg == 16'd7)
                begin
                    blk_cnt_next = '0;
                    grp_next     = '0;
                    phase_next   = after_block(17'd8, decl_len_reg);
                end
            end
            PH_BLK_HDR:
            begin
                blk_cnt_next = cnt_inc;
                if (blk_cnt_reg == 16'd0)
                begin
                    blk_type_next = packet_byte;
                end
                else if (blk_cnt_reg == 16'd2)
                begin
                    blk_len_next = {packet_byte, 8'b0};
                end
                else if (blk_cnt_reg == 16'd3)
                begin
                    if (blk_end > {4'b0, packet_length})
                    begin
                        blk_cnt_next = blk_cnt_reg;
                        err_next     = ST_BLK_OVER;
                        phase_next   = PH_IDLE;
                    end
                    else
                    begin
                        blk_len_next = blk_total[15:0];
                        blk_cnt_next = '0;
                        grp_next     = '0;
                        if (blk_total == 19'd4)
                            phase_next = after_block(q_next_byte, decl_len_reg);
                        else
                            phase_next = (blk_type_reg == BT_DLRR) ? PH_DLRR : PH_SKIP;
                    end
                end
            end
            PH_DLRR, PH_SKIP:
            begin
                if (phase_reg == PH_DLRR)
                begin
                    shift_next = shift_in;
                    // ssrc, lrr, dlrr complete on the twelfth byte of a group
                    if (grp_reg == 4'(DLRR_GROUP - 1) && recv_only)
                    begin
                        evt.rtt  = 1'b1;
                        evt.src  = shift_in[95:64];
                        evt.diff = now_compact_ntp - shift_in[63:32] - shift_in[31:0];
                    end
                end
                blk_cnt_next = cnt_inc;
                grp_next     = (grp_reg == 4'(DLRR_GROUP - 1)) ? 4'd0 : grp_reg + 4'd1;
                if ({1'b0, cnt_inc} + 17'd4 >= {1'b0, blk_len_reg})
                begin
                    blk_cnt_next = '0;
                    grp_next     = '0;
                    phase_next   = after_block(q_next_byte, decl_len_reg);
                end
            end
            default:
            begin
            end
        endcase

        if (pos_reg != 16'hFFFF)
            pos_next = pos_reg + 16'd1;

        if (last_byte)
        begin
            st = err_next;
            if (phase_next == PH_HEADER && err_next == ST_OK)
            begin
                if (pos_reg < 16'd1)
                    st = ST_NOT_XR;
                else if (pos_reg < 16'd3)
                    st = ST_LEN_OVER;
            end
            evt.stat      = 1'b1;
            evt.status    = st;
            phase_next    = PH_HEADER;
            pos_next      = '0;
            decl_len_next = '0;
            blk_len_next  = '0;
            blk_type_next = '0;
            blk_cnt_next  = '0;
            grp_next      = '0;
            shift_next    = '0;
            err_next      = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            pos_reg      <= '0;
            decl_len_reg <= '0;
            blk_len_reg  <= '0;
            blk_type_reg <= '0;
            blk_cnt_reg  <= '0;
            grp_reg      <= '0;
            shift_reg    <= '0;
            err_reg      <= ST_OK;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            decl_len_reg <= decl_len_next;
            blk_len_reg  <= blk_len_next;
            blk_type_reg <= blk_type_next;
            blk_cnt_reg  <= blk_cnt_next;
            grp_reg      <= grp_next;
            shift_reg    <= shift_next;
            err_reg      <= err_next;
        end
    end

endmodule

// ===== sim/tb_rtcp_xr_dlrr_rtt_parser_core.sv =====
// testbench for the rtcp xr dlrr round-trip parser: packet stimulus, predictor and result check
module tb_rtcp_xr_dlrr_rtt_parser_core;
    import rxdlrr_pkg::*;

    localparam logic [7:0] BT_RRT = 8'd4;  // receiver reference time block, body skipped

    typedef struct {
        bit        kind;
        bit [31:0] src;
        bit [31:0] rtt;
        bit [1:0]  st;
        bit        last;
    } xr_result_t;

    class rtt_scoreboard;
        bit           recv_only;
        bit [15:0]    pos;
        phase_t       phase;
        bit [15:0]    decl_len;
        bit [15:0]    blk_len;
        bit [7:0]     blk_type;
        bit [15:0]    blk_cnt;
        bit [95:0]    fields;  // ssrc : lrr : dlrr of the current sub-block
        bit [1:0]     err;
        xr_result_t   awaited[$];
        int           mismatches;
        int           rtt_checked;
        int           status_checked;

        function new();
            recv_only = 1'b1;
            restart();
        endfunction

        function void restart();
            pos = '0;
            phase = PH_HEADER;
            decl_len = '0;
            blk_len = '0;
            blk_type = '0;
            blk_cnt = '0;
            fields = '0;
            err = ST_OK;
        endfunction

        function void note_recv_only(bit v);
            recv_only = v;
        endfunction

        function void fail_with(bit [1:0] code);
            err = code;
            phase = PH_IDLE;
        endfunction

        // q is the byte index just after the finished header or block
        function void open_block(bit [31:0] q);
            blk_cnt = '0;
            phase = (q + 32'd4 < {16'h0, decl_len}) ? PH_BLK_HDR : PH_IDLE;
        endfunction

        // floor of the signed 16.16 difference times 1000, wrapped to 32 bits
        function bit [31:0] rtt_ms_of(bit [31:0] now, bit [31:0] lrr, bit [31:0] dlrr);
            bit [31:0] d;
            bit [63:0] whole;
            bit [63:0] frac;
            d = now - lrr - dlrr;
            whole = {{48{d[31]}}, d[31:16]};
            frac = ({48'h0, d[15:0]} * RTT_SCALE) >> FRAC_BITS;
            return 32'(whole * RTT_SCALE + frac);
        endfunction

        function void note_input(bit [7:0] b, bit [15:0] plen, bit [31:0] now, bit last);
            bit [31:0]  p;
            bit [31:0]  total;
            bit [1:0]   st;
            xr_result_t made[$];
            p = {16'h0, pos};
            case (phase)
                PH_HEADER:
                begin
                    if (p == 1)
                    begin
                        if (b != PT_XR)
                            fail_with(ST_NOT_XR);
                    end
                    else if (p == 2)
                        decl_len = {b, 8'h00};
                    else if (p == 3)
                    begin
                        total = ({16'h0, decl_len | {8'h00, b}} + 32'd1) << 2;
                        if (total > {16'h0, plen})
                            fail_with(ST_LEN_OVER);
                        else
                            decl_len = total[15:0];
                    end
                    else if (p == 7)
                        open_block(32'd8);
                end
                PH_BLK_HDR:
                begin
                    if (blk_cnt == 3)
                    begin
                        total = ({16'h0, blk_len | {8'h00, b}} + 32'd1) << 2;
                        if (p - 32'd3 + total > {16'h0, plen})
                            fail_with(ST_BLK_OVER);
                        else
                        begin
                            blk_len = total[15:0];
                            if (total == 32'd4)
                                open_block(p + 32'd1);
                            else
                            begin
                                blk_cnt = '0;
                                phase = (blk_type == BT_DLRR) ? PH_DLRR : PH_SKIP;
                            end
                        end
                    end
                    else
                    begin
                        if (blk_cnt == 0)
                            blk_type = b;
                        else if (blk_cnt == 2)
                            blk_len = {b, 8'h00};
                        blk_cnt++;
                    end
                end
                PH_DLRR, PH_SKIP:
                begin
                    if (phase == PH_DLRR)
                    begin
                        fields = {fields[87:0], b};
                        if (blk_cnt % DLRR_GROUP == DLRR_GROUP - 1 && recv_only)
                            made.push_back('{KIND_RTT, fields[95:64],
                                             rtt_ms_of(now, fields[63:32], fields[31:0]),
                                             ST_OK, 1'b0});
                    end
                    blk_cnt++;
                    if ({16'h0, blk_cnt} + 32'd4 >= {16'h0, blk_len})
                        open_block(p + 32'd1);
                end
                default: ;
            endcase

            if (pos != 16'hFFFF)
                pos++;

            if (last)
            begin
                st = err;
                // packet cut short inside the fixed header
                if (phase == PH_HEADER && st == ST_OK)
                begin
                    if (p < 1)
                        st = ST_NOT_XR;
                    else if (p < 3)
                        st = ST_LEN_OVER;
                end
                made.push_back('{KIND_STATUS, 32'h0, 32'h0, st, 1'b0});
                restart();
            end
            if (made.size() > 0)
                made[made.size() - 1].last = 1'b1;
            foreach (made[i])
                awaited.push_back(made[i]);
        endfunction

        function void check_result(logic kind, logic [31:0] src, logic [31:0] rtt,
                                   logic [1:0] st, logic last);
            xr_result_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d src %h rtt %0d status %0d last %0d",
                             kind, src, $signed(rtt), st, last);
                return;
            end
            want = awaited.pop_front();
            if (want.kind == KIND_RTT)
                rtt_checked++;
            else
                status_checked++;
            if (kind !== want.kind || src !== want.src || rtt !== want.rtt ||
                st !== want.st || last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result differs: expected kind %0d src %h rtt %0d status %0d ",
                              "last %0d, got kind %0d src %h rtt %0d status %0d last %0d"},
                             want.kind, want.src, $signed(want.rtt), want.st, want.last,
                             kind, src, $signed(rtt), st, last);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         packet_byte;
    logic [15:0]        packet_length;
    logic [31:0]        now_compact_ntp;
    logic               last_byte;
    logic               out_valid;
    logic               out_ready;
    logic               result_kind;
    logic [31:0]        source_id;
    logic signed [31:0] rtt_ms;
    logic [1:0]         status;
    logic               last_result;

    rtt_scoreboard sb;
    bit [7:0]      pkt[$];
    int            blk_at;
    int            hold_cycles = 0;
    bit            steady = 1'b0;
    int            items_sent = 0;
    int            packets_sent = 0;
    int            cfg_writes = 0;

    rtcp_xr_dlrr_rtt_parser_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .packet_byte     (packet_byte),
        .packet_length   (packet_length),
        .now_compact_ntp (now_compact_ntp),
        .last_byte       (last_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_kind     (result_kind),
        .source_id       (source_id),
        .rtt_ms          (rtt_ms),
        .status          (status),
        .last_result     (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("rtcp_xr_dlrr_rtt_parser_core: mismatch");
        $finish;
    end

    // sample both handshakes and register writes at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.note_recv_only(cfg_wdata);
            if (in_valid && in_ready)
                sb.note_input(packet_byte, packet_length, now_compact_ntp, last_byte);
            if (out_valid && out_ready)
                sb.check_result(result_kind, source_id, rtt_ms, status, last_result);
        end
    end

    // result side: random stalls, plus a long hold-off when asked
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else
                out_ready <= steady || ($urandom_range(0, 99) >= 8);
        end
    end

    task send_item(input bit [7:0] b, input bit [15:0] plen, input bit [31:0] now,
                   input bit last);
        while (!steady && $urandom_range(0, 99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        packet_byte <= b;
        packet_length <= plen;
        now_compact_ntp <= now;
        last_byte <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // per-byte time when jitter is set, else one time for the whole packet
    task send_packet(input bit [15:0] plen, input bit [31:0] now, input bit jitter);
        int i;
        for (i = 0; i < pkt.size(); i++)
            send_item(pkt[i], plen, jitter ? $urandom() : now, i == pkt.size() - 1);
        packets_sent++;
    endtask

    // one edge first so the last accepted item is already noted
    task settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task write_recv_only(input bit v);
        settle();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        cfg_writes++;
    endtask

    task put32(input bit [31:0] v);
        pkt.push_back(v[31:24]);
        pkt.push_back(v[23:16]);
        pkt.push_back(v[15:8]);
        pkt.push_back(v[7:0]);
    endtask

    task start_header(input bit [7:0] pt);
        pkt.delete();
        pkt.push_back(8'($urandom()));
        pkt.push_back(pt);
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        put32($urandom());
        blk_at = -1;
    endtask

    task fix_length();
        bit [15:0] w;
        w = 16'(pkt.size() / 4 - 1);
        pkt[2] = w[15:8];
        pkt[3] = w[7:0];
    endtask

    task cut_to(input int n);
        while (pkt.size() > n)
            void'(pkt.pop_back());
    endtask

    // lrr and dlrr chosen in half of the groups so that the round trip is small and positive
    task put_dlrr_group(input bit [31:0] now);
        bit [31:0] lrr;
        bit [31:0] dlrr;
        lrr = $urandom();
        case ($urandom_range(0, 5))
            0, 1: dlrr = $urandom();
            2: dlrr = now - lrr - (32'h8000_0000 - $urandom_range(0, 2));
            default: dlrr = now - lrr - $urandom_range(0, 32'h0003_FFFF);
        endcase
        put32($urandom());
        put32(lrr);
        put32(dlrr);
    endtask

    task add_block(input bit [7:0] bt, input bit [15:0] w, input bit [31:0] now);
        int groups;
        int rest;
        int k;
        groups = (bt == BT_DLRR) ? w / 3 : 0;
        rest = int'(w) * 4 - groups * 12;
        blk_at = pkt.size();
        pkt.push_back(bt);
        pkt.push_back(8'($urandom()));
        pkt.push_back(w[15:8]);
        pkt.push_back(w[7:0]);
        for (k = 0; k < groups; k++)
            put_dlrr_group(now);
        for (k = 0; k < rest; k++)
            pkt.push_back(8'($urandom()));
    endtask

    task random_packet();
        int        nblk;
        int        k;
        int        w;
        int        choice;
        bit [7:0]  bt;
        bit [15:0] plen;
        bit [31:0] now;
        now = $urandom();
        start_header(PT_XR);
        nblk = $urandom_range(0, 2);
        for (k = 0; k < nblk; k++)
        begin
            choice = $urandom_range(0, 9);
            if (choice < 6)
            begin
                bt = BT_DLRR;
                w = 3 * $urandom_range(1, 2);
                // partial trailing group now and then
                if ($urandom_range(0, 3) == 0)
                    w += $urandom_range(1, 2);
            end
            else if (choice < 8)
            begin
                bt = BT_RRT;
                w = $urandom_range(0, 1) ? 2 : $urandom_range(0, 4);
            end
            else
            begin
                bt = 8'($urandom());
                w = $urandom_range(0, 4);
            end
            add_block(bt, 16'(w), now);
        end
        fix_length();
        plen = 16'(pkt.size());

        case ($urandom_range(0, 11))
            0: pkt[1] = pkt[1] ^ (8'h01 << $urandom_range(0, 7));
            1: plen = plen - 16'($urandom_range(1, 8));
            2:
            begin
                if (blk_at >= 0)
                begin
                    w = {pkt[blk_at + 2], pkt[blk_at + 3]} + $urandom_range(1, 300);
                    pkt[blk_at + 2] = w[15:8];
                    pkt[blk_at + 3] = w[7:0];
                end
            end
            3: cut_to($urandom_range(1, pkt.size() - 1));
            4: repeat ($urandom_range(1, 8)) pkt.push_back(8'($urandom()));
            5: plen = plen + 16'($urandom_range(1, 100));
            6:
            begin
                pkt.delete();
                repeat ($urandom_range(2, 24)) pkt.push_back(8'($urandom()));
                if ($urandom_range(0, 1))
                    pkt[1] = PT_XR;
                plen = 16'($urandom());
            end
            default: ;
        endcase
        send_packet(plen, now, $urandom_range(0, 7) == 0);
    endtask

    initial
    begin
        int        k;
        int        n;
        int        start_items;
        bit [31:0] now;
        bit [7:0]  bad_pt[2];

        sb = new();
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= 1'b0;
        in_valid <= 1'b0;
        packet_byte <= '0;
        packet_length <= '0;
        now_compact_ntp <= '0;
        last_byte <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_recv_only(1'b1);
        now = $urandom();

        // header alone, then a header declaring only one word
        start_header(PT_XR);
        fix_length();
        send_packet(16'(pkt.size()), now, 1'b0);
        start_header(PT_XR);
        send_packet(16'(pkt.size()), now, 1'b0);

        // round trips at zero, both signed extremes, minus one unit and a double wrap
        now = 32'h8000_0000;
        start_header(PT_XR);
        pkt.push_back(BT_DLRR);
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        pkt.push_back(8'd15);
        put32(32'h0000_0000); put32(now); put32(32'h0);
        put32(32'hFFFF_FFFF); put32(now - 32'h7FFF_FFFF); put32(32'h0);
        put32(32'h1234_5678); put32(32'h0); put32(32'h0);
        put32(32'hA5A5_5A5A); put32(now); put32(32'h1);
        put32(32'h5A5A_A5A5); put32(32'hFFFF_FFFF); put32(32'hFFFF_FFFF);
        fix_length();
        send_packet(16'(pkt.size()), now, 1'b0);

        // skipped types, an empty block and a dlrr block with a partial group
        now = $urandom();
        start_header(PT_XR);
        add_block(BT_RRT, 16'd2, now);
        add_block(8'hFF, 16'd0, now);
        add_block(BT_DLRR, 16'd4, now);
        add_block(8'h00, 16'd3, now);
        fix_length();
        send_packet(16'(pkt.size()), now, 1'b1);

        bad_pt[0] = 8'h00;
        bad_pt[1] = 8'hFF;
        foreach (bad_pt[i])
        begin
            start_header(bad_pt[i]);
            add_block(BT_DLRR, 16'd3, now);
            fix_length();
            send_packet(16'(pkt.size()), now, 1'b0);
        end

        // declared length far beyond the packet
        start_header(PT_XR);
        pkt[2] = 8'hFF;
        pkt[3] = 8'hFF;
        send_packet(16'hFFFF, now, 1'b0);

        start_header(PT_XR);
        add_block(BT_DLRR, 16'd3, now);
        fix_length();
        send_packet(16'h0000, now, 1'b0);

        // block running past the packet
        start_header(PT_XR);
        add_block(BT_DLRR, 16'd3, now);
        fix_length();
        pkt[blk_at + 2] = 8'hFF;
        pkt[blk_at + 3] = 8'hFF;
        send_packet(16'(pkt.size()), now, 1'b0);

        // packet ending inside the fixed header
        for (k = 1; k <= 4; k++)
        begin
            start_header(PT_XR);
            add_block(BT_DLRR, 16'd3, now);
            fix_length();
            cut_to(k);
            send_packet(16'd24, now, 1'b0);
        end

        // packet ending inside a dlrr block after one complete group
        start_header(PT_XR);
        add_block(BT_DLRR, 16'd6, now);
        fix_length();
        cut_to(27);
        send_packet(16'd44, now, 1'b0);

        // bytes past the declared length
        start_header(PT_XR);
        add_block(BT_RRT, 16'd2, now);
        fix_length();
        repeat (6) pkt.push_back(8'($urandom()));
        send_packet(16'(pkt.size()), now, 1'b0);

        write_recv_only(1'b0);
        start_header(PT_XR);
        add_block(BT_DLRR, 16'd6, now);
        fix_length();
        send_packet(16'(pkt.size()), now, 1'b0);
        write_recv_only(1'b1);

        // long skipped block with trailing bytes and a generous packet length
        start_header(PT_XR);
        add_block(BT_RRT, 16'd30, now);
        fix_length();
        repeat (8) pkt.push_back(8'($urandom()));
        send_packet(16'hFFFF, now, 1'b0);

        start_items = items_sent;
        n = 0;
        while (items_sent - start_items < 420)
        begin
            if (n == 2)
                hold_cycles = 300;
            if (n == 5)
                settle();
            steady = (n >= 7 && n < 12);
            if (n % 7 == 6)
                write_recv_only($urandom_range(0, 3) != 0);
            random_packet();
            n++;
        end

        settle();
        repeat (10) @(posedge clk);
        $display("%0d packets in %0d bytes, recv_only written %0d times",
                 packets_sent, items_sent, cfg_writes);
        $display("%0d round-trip and %0d status results checked, %0d wrong",
                 sb.rtt_checked, sb.status_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("rtcp_xr_dlrr_rtt_parser_core: match");
        else
            $display("rtcp_xr_dlrr_rtt_parser_core: mismatch");
        $finish;
    end

endmodule
